/* hdl/ktt_pkg.sv */
// Package for the keyed timestamp table: payload structs, opcodes, controller states
// and the command and status bundles between controller and datapath. No dependencies.
package ktt_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 16;
  localparam int CONN_KEY_W   = 16;
  localparam int TIME_W       = 32;

  typedef enum logic [1:0] {
    OP_TOUCH  = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [CONN_KEY_W-1:0] conn_key;
    logic [TIME_W-1:0]     now_time;
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0] seen_time;
    logic              hit;
    logic              status;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic start;    // capture the request and clear the match trackers
    logic scan_en;  // read the entry at the scan index and advance
    logic commit;   // apply the table update and load the result register
  } cmd_t;

  typedef struct packed {
    logic scan_last;  // the scan index points at the last entry
    logic out_free;   // the result register can take a new result this cycle
  } stat_t;

endpackage

/* hdl/ktt_ctrl.sv */
// Controller state machine for the keyed timestamp table.
// Depends on ktt_pkg for the state enum and the command and status structs.
module ktt_ctrl import ktt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.start   = 1'b0;
    cmd.scan_en = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last entry read is compared in this cycle.
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/ktt_datapath.sv */
// Datapath of the keyed timestamp table: entry memory, valid flags, scan pipeline,
// match and free-slot trackers, and the result register. Depends on ktt_pkg.
module ktt_datapath import ktt_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  req_t in_data,
  input  cmd_t cmd,
  output stat_t stat,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Entry storage; contents are only trusted where the valid flag is set.
  logic [KEY_BITS-1:0] key_mem  [ENTRIES];
  logic [TIME_W-1:0]   time_mem [ENTRIES];
  logic [ENTRIES-1:0]  entry_valid_r;

  logic [1:0]          req_op_r;
  logic [KEY_BITS-1:0] req_key_r;
  logic [TIME_W-1:0]   req_time_r;
  logic [31:0]         key_ext;

  logic [IDX_W-1:0]    scan_idx_r;
  logic                rd_pend_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                rd_valid_r;
  logic [KEY_BITS-1:0] rd_key_r;
  logic [TIME_W-1:0]   rd_time_r;

  logic                found_r;
  logic [IDX_W-1:0]    found_idx_r;
  logic [TIME_W-1:0]   found_time_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;

  logic                out_valid_r;
  rsp_t                out_data_r;

  logic                rd_match;
  logic                rd_free;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic                set_valid;
  logic                clr_valid;
  rsp_t                rsp;

  assign key_ext = {{(32 - CONN_KEY_W){1'b0}}, in_data.conn_key};

  assign stat.scan_last = (scan_idx_r == IDX_W'(ENTRIES - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op_r   <= in_data.opcode;
      req_key_r  <= key_ext[KEY_BITS-1:0];
      req_time_r <= in_data.now_time;
    end
  end

  // Scan: one registered read per cycle, compared in the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_en;
      if (cmd.start) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_en) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      rd_key_r   <= key_mem[scan_idx_r];
      rd_time_r  <= time_mem[scan_idx_r];
      rd_valid_r <= entry_valid_r[scan_idx_r];
      rd_idx_r   <= scan_idx_r;
    end
  end

  assign rd_match = rd_pend_r && rd_valid_r && (rd_key_r == req_key_r);
  assign rd_free  = rd_pend_r && !rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.start) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (rd_match && !found_r) begin
        found_r <= 1'b1;
      end
      if (rd_free && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_match && !found_r) begin
      found_idx_r  <= rd_idx_r;
      found_time_r <= rd_time_r;
    end
    if (rd_free && !free_found_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

  // Update decision and result from the finished scan.
  always_comb begin
    wr_en         = 1'b0;
    wr_idx        = found_idx_r;
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    rsp.seen_time = '0;
    rsp.hit       = 1'b0;
    rsp.status    = 1'b0;
    case (req_op_r)
      OP_TOUCH: begin
        if (found_r) begin
          wr_en   = 1'b1;
          rsp.hit = 1'b1;
        end else if (free_found_r) begin
          wr_en     = 1'b1;
          wr_idx    = free_idx_r;
          set_valid = 1'b1;
        end else begin
          rsp.status = 1'b1;
        end
      end
      OP_QUERY: begin
        if (found_r) begin
          rsp.seen_time = found_time_r;
          rsp.hit       = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found_r) begin
          clr_valid = 1'b1;
          rsp.hit   = 1'b1;
        end
      end
      default: begin
        // Undefined opcode: nothing changes, all-zero result.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      key_mem[wr_idx]  <= req_key_r;
      time_mem[wr_idx] <= req_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (cmd.commit) begin
      if (set_valid) begin
        entry_valid_r[wr_idx] <= 1'b1;
      end else if (clr_valid) begin
        entry_valid_r[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/keyed_timestamp_table_core.sv */
// Keyed timestamp table: top level joining the controller and the datapath.
// One transaction at a time: requests are accepted only in the idle state. Each one runs
// the one-entry-per-cycle scan of the single-read-port entry memory plus setup, compare
// drain and write-back, and write-back waits until the result register is free.
// Reset (rst_n, synchronous, active low) empties the table and drops any pending result.
module keyed_timestamp_table_core import ktt_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  // The controller sequences each transaction through capture, scan, drain and
  // update. Only the command and status bundles cross between the two halves.
  cmd_t  cmd;
  stat_t stat;

  ktt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the entries, scans them in ascending order for the key
  // and for the lowest free slot, then applies the update and registers the
  // result. The result register lets a finished result wait for the consumer.
  ktt_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sim/keyed_timestamp_table_core_tb.sv */
// Self-checking testbench for keyed_timestamp_table_core: directed and random
// touch, query and remove transactions checked against a shadow copy of the table.
// Depends on ktt_pkg and the keyed_timestamp_table_core RTL only.
`timescale 1ns / 100ps

module keyed_timestamp_table_core_tb;
  import ktt_pkg::*;

  localparam int ENTRIES  = ENTRIES_DEF;
  localparam int KEY_BITS = KEY_BITS_DEF;

  // Opcode 3 is not part of op_t; the block must answer it with an all-zero result.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Receiver hold-off length, in cycles, used to back the table up to its input.
  localparam int HOLD_CYCLES = 300;
  // Cycles to watch for stray results after the last expected one.
  localparam int TAIL_CYCLES = 40;
  localparam int POOL_SIZE   = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  keyed_timestamp_table_core #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the table. Keys and times are only read where the valid flag is set.
  logic                shadow_valid [ENTRIES] = '{default: 1'b0};
  logic [KEY_BITS-1:0] shadow_key   [ENTRIES];
  logic [TIME_W-1:0]   shadow_time  [ENTRIES];

  req_t req_backlog[$];    // requests waiting to be offered on the input channel
  rsp_t awaited_rsp[$];    // predicted responses, oldest first

  int   n_queued = 0;      // requests put into the backlog so far
  int   n_accepted = 0;    // requests taken by the block
  int   n_done = 0;        // responses compared against a prediction
  int   mismatch_count = 0;
  logic quiet = 1'b0;      // when set, neither side inserts idle cycles
  logic rx_hold = 1'b0;    // long receiver hold-off, driven by its own process
  int   tx_gap_left = 0;
  int   rx_stall_left = 0;

  logic [CONN_KEY_W-1:0] key_pool [POOL_SIZE];

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one request to the shadow table and returns the response it must produce.
  // A key lives in at most one valid slot, so the first match is the only match; a new
  // key claims the lowest free slot, and a touch with neither is reported as table full.
  function automatic rsp_t apply_request(req_t r);
    logic [KEY_BITS-1:0] k;
    int                  found;
    int                  spare;
    rsp_t                res;
    k     = r.conn_key[KEY_BITS-1:0];
    res   = '0;
    found = -1;
    spare = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_key[i] == k) found = i;
      if (spare < 0 && !shadow_valid[i]) spare = i;
    end
    case (r.opcode)
      OP_TOUCH: begin
        if (found >= 0) begin
          shadow_time[found] = r.now_time;
          res.hit = 1'b1;
        end else if (spare >= 0) begin
          shadow_valid[spare] = 1'b1;
          shadow_key[spare]   = k;
          shadow_time[spare]  = r.now_time;
        end else begin
          res.status = 1'b1;
        end
      end
      OP_QUERY: begin
        if (found >= 0) begin
          res.seen_time = shadow_time[found];
          res.hit       = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found >= 0) begin
          shadow_valid[found] = 1'b0;
          res.hit             = 1'b1;
        end
      end
      default: begin
        // Reserved opcode: nothing changes and every field stays zero.
      end
    endcase
    return res;
  endfunction

  task automatic queue_req(input logic [1:0] op, input logic [CONN_KEY_W-1:0] key,
                           input logic [TIME_W-1:0] stamp);
    req_t r;
    r.opcode   = op;
    r.conn_key = key;
    r.now_time = stamp;
    req_backlog.push_back(r);
    n_queued++;
  endtask

  // Random traffic over the first pool_used keys of the pool. With more keys in play
  // than slots, the table hovers near full, so misses, hits and full-table touches all
  // occur often. A few keys are fully random to exercise unrelated misses.
  task automatic queue_random(input int count, input int pool_used);
    int                    pick;
    logic [1:0]            op;
    logic [CONN_KEY_W-1:0] key;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = OP_TOUCH;
      else if (pick < 75) op = OP_QUERY;
      else if (pick < 95) op = OP_REMOVE;
      else                op = OP_RESERVED;
      if ($urandom_range(0, 15) == 0) key = CONN_KEY_W'($urandom);
      else                            key = key_pool[$urandom_range(0, pool_used - 1)];
      queue_req(op, key, $urandom);
    end
  endtask

  // Prints one line per mismatch, up to a cap that keeps the log short, and counts all.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("mismatch at response %0d: %s got %0h expected %0h", n_done, what, got, want);
    end
  endtask

  // Input side. A transaction is predicted at the edge where it is accepted; the next
  // request, or an idle burst, is chosen in the same step, and in_valid gets exactly one
  // nonblocking update per edge so back-to-back requests stay high.
  always @(posedge clk) begin : tx_side
    logic nxt_valid;
    req_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_rsp.push_back(apply_request(in_data));
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (req_backlog.size() > 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            tx_gap_left = $urandom_range(0, 18);
          end else begin
            nxt_data  = req_backlog.pop_front();
            nxt_valid = 1'b1;
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Output side. Responses are compared field by field with the oldest prediction.
  // The ready line drops in random bursts and during the long hold-off.
  always @(posedge clk) begin : rx_side
    rsp_t want;
    logic rdy;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch("unexpected response, seen_time", out_data.seen_time, '0);
      end else begin
        want = awaited_rsp.pop_front();
        if (out_data.seen_time !== want.seen_time)
          report_mismatch("seen_time", out_data.seen_time, want.seen_time);
        if (out_data.hit !== want.hit)
          report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        n_done++;
      end
    end
    if (!rst_n || quiet) begin
      rdy = 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      rdy = 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      rx_stall_left = $urandom_range(0, 18);
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_ready <= rdy && !rx_hold;
  end

  // Long receiver hold-off early in the random traffic. The sender keeps offering
  // requests, so the result register fills and the block must stall its input.
  initial begin
    wait (n_accepted >= 130);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Guard against a hang. The slowest correct run is well under 1 ms.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty table, key and time extremes, every opcode including the
    // reserved one, filling the table, a touch on a full table, an update of an
    // existing key while full, and reuse of a freed slot.
    queue_req(OP_TOUCH, 16'h0000, 32'hFFFF_FFFF);
    queue_req(OP_QUERY, 16'h0000, 32'h0000_0000);
    queue_req(OP_QUERY, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(OP_REMOVE, 16'hFFFF, 32'h0000_0000);
    queue_req(OP_RESERVED, 16'h0000, 32'h1234_5678);
    queue_req(OP_QUERY, 16'h0000, 32'h0000_0000);
    // Walking-one keys take slots 1 to 15 in order, leaving the table full.
    for (int i = 1; i < ENTRIES; i++) begin
      queue_req(OP_TOUCH, 16'(1 << i), $urandom);
    end
    queue_req(OP_TOUCH, 16'hFFFF, 32'hDEAD_BEEF);
    queue_req(OP_TOUCH, 16'h0000, 32'h0000_0000);
    queue_req(OP_QUERY, 16'h0000, 32'hFFFF_FFFF);
    queue_req(OP_REMOVE, 16'h0020, 32'h0000_0000);
    queue_req(OP_TOUCH, 16'hFFFF, 32'h5A5A_A5A5);
    queue_req(OP_QUERY, 16'hFFFF, 32'h0000_0000);
    queue_req(OP_REMOVE, 16'h0020, 32'h0000_0000);

    // The pool starts with the keys left in the table, so random removes can drain it.
    key_pool[0] = 16'h0000;
    for (int i = 1; i < ENTRIES; i++) key_pool[i] = 16'(1 << i);
    key_pool[5] = 16'hFFFF;
    for (int i = ENTRIES; i < POOL_SIZE; i++) key_pool[i] = CONN_KEY_W'($urandom);

    // The sender pauses here until every response of the directed part is back.
    wait (n_done == n_queued);
    queue_random(500, 24);
    wait (n_done == n_queued);
    queue_random(500, POOL_SIZE);
    wait (n_done == n_queued);

    // Closing stretch at full rate on both sides.
    quiet = 1'b1;
    queue_random(200, POOL_SIZE);
    wait (n_done == n_queued);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* keyed_timestamp_table_core.f */
hdl/ktt_pkg.sv
hdl/ktt_ctrl.sv
hdl/ktt_datapath.sv
hdl/keyed_timestamp_table_core.sv
sim/keyed_timestamp_table_core_tb.sv
